FILE: hw/rtl/sfr_pkg.sv
// Shared types, constants and helpers for the serial frame receiver.
// No dependencies; imported by the top level and the byte unit.
package sfr_pkg;

	// defaults and fixed frame geometry
	localparam int BUF_LEN_DEF  = 100;
	localparam int NUM_CH_DEF   = 9;
	localparam int DATA_LEN     = 41;
	localparam int CMD_LEN      = 7;
	localparam int HDR_LEN      = 4;
	localparam int WORD_BYTES   = 4;
	localparam int SCAN_W       = $clog2(DATA_LEN);
	localparam int CH_W         = 4;

	// header bytes
	localparam logic [7:0] HDR_B0   = 8'hFF;
	localparam logic [7:0] HDR_B1   = 8'h55;
	localparam logic [7:0] HDR_B2   = 8'hAA;
	localparam logic [7:0] HDR_DATA = 8'h10;
	localparam logic [7:0] HDR_CMD  = 8'h77;

	// command data codes; only CMD_PIN_SET is used, to raise the pin
	localparam logic [7:0] CMD_PIN_CLR = 8'd101;
	localparam logic [7:0] CMD_PIN_SET = 8'd104;

	// result kinds
	localparam logic [2:0] K_STORED   = 3'd0;
	localparam logic [2:0] K_OVERFLOW = 3'd1;
	localparam logic [2:0] K_CHANNEL  = 3'd2;
	localparam logic [2:0] K_COMMAND  = 3'd3;
	localparam logic [2:0] K_DATA_BAD = 3'd4;
	localparam logic [2:0] K_CMD_BAD  = 3'd5;

	localparam logic [31:0] NEG_BASE = 32'h7FFF_FFFF;

	typedef enum logic [1:0] {
		OP_NONE = 2'd0,
		OP_HDR  = 2'd1,
		OP_SUM  = 2'd2,
		OP_WORD = 2'd3
	} scan_op_t;

	// control from sequencer to the byte unit
	typedef struct packed {
		scan_op_t   op;
		logic       first;   // byte is first of its pass
		logic [1:0] pos;     // offset within header
		logic [7:0] fourth;  // expected fourth header byte
	} scan_ctrl_t;

	function automatic logic [7:0] hdr_byte(input logic [1:0] pos, input logic [7:0] fourth);
		logic [7:0] b;
		case (pos)
			2'd0:    b = HDR_B0;
			2'd1:    b = HDR_B1;
			2'd2:    b = HDR_B2;
			default: b = fourth;
		endcase
		return b;
	endfunction

	// words above 0x7FFFFFFF map to 0x7FFFFFFF - w (mod 2^32)
	function automatic logic [31:0] map_channel(input logic [31:0] w);
		return w[31] ? (NEG_BASE - w) : w;
	endfunction

endpackage

FILE: hw/rtl/serial_frame_receiver_unit.sv
// Top level of the serial frame receiver: sequencer, output register and the
// buffer and byte unit. Depends on sfr_pkg, sfr_buffer and sfr_scan_unit.
//
// Usage:
//  - Input channel (in_valid / in_stall, rx_byte): one received UART word per
//    handshake. in_stall is high while a word is being worked on.
//  - Output channel (out_valid / out_stall): result words, one per handshake,
//    held stable while out_stall is high. last marks the final result of a
//    received word; pin_level is the control pin after that word.
//  - Time per word depends on the windows it opens: none, a command header
//    test, both header tests, a command frame, or a good data frame, which
//    also hands out one result per channel. The single buffer read port,
//    one byte a cycle, sets this.
//  - The output register frees the sequencer, so the next word is taken
//    while the final result still waits; out_stall holds the sequencer only
//    when a further result must be loaded.
//  - Reset empties the buffer count and drops the pin; buffer contents are
//    not cleared, since no window reaches past the bytes stored since the
//    last emptying.
module serial_frame_receiver_unit
	import sfr_pkg::*;
#(
	parameter int BUF_LEN      = BUF_LEN_DEF,
	parameter int NUM_CHANNELS = NUM_CH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         kind,
	output logic [CH_W-1:0]    channel,
	output logic signed [31:0] channel_value,
	output logic [7:0]         cmd_number,
	output logic [7:0]         cmd_data,
	output logic               pin_level,
	output logic               last
);

	localparam int CW = $clog2(BUF_LEN + 1);
	localparam int AW = $clog2(BUF_LEN);

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_DHDR = 8'b0000_0010,  // data header test
		ST_CHDR = 8'b0000_0100,  // command header test
		ST_DSUM = 8'b0000_1000,  // data frame sum
		ST_CSUM = 8'b0001_0000,  // command frame sum, captures number and data
		ST_WORD = 8'b0010_0000,  // gather one channel word
		ST_PUT  = 8'b0100_0000,  // hand out one channel
		ST_RES  = 8'b1000_0000   // hand out a single result
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     cnt_q;
	logic [CW-1:0]     cnt_inc;
	logic [AW-1:0]     base_q;
	logic [7:0]        byte_q;
	logic [SCAN_W-1:0] iss_q;
	logic [SCAN_W-1:0] rcv_q;
	logic              rd_vld_s1;
	logic [CH_W-1:0]   ch_q;
	logic [2:0]        res_kind_q;
	logic              pin_q;
	logic              out_valid_q;

	logic [2:0]        kind_q;
	logic [CH_W-1:0]   channel_q;
	logic [31:0]       value_q;
	logic [7:0]        num_q;
	logic [7:0]        dat_q;
	logic              pin_out_q;
	logic              last_q;

	logic              accept;
	logic              out_free;
	logic              ld_put;
	logic              ld_res;
	logic              scanning;
	logic [SCAN_W-1:0] scan_len;
	logic              scan_done;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic [7:0]        rd_data;
	logic              wr_en;
	scan_ctrl_t        sctrl;
	logic              hdr_ok;
	logic [7:0]        sum;
	logic [31:0]       word;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid & ~in_stall;
	assign out_free = ~out_valid_q | ~out_stall;
	assign ld_put   = (state_q == ST_PUT) & out_free;
	assign ld_res   = (state_q == ST_RES) & out_free;
	assign cnt_inc  = cnt_q + CW'(1);
	assign wr_en    = accept & (cnt_q < CW'(BUF_LEN));

	// pass length and unit operation per state
	always_comb begin
		scan_len    = '0;
		sctrl.op    = OP_NONE;
		sctrl.fourth = HDR_DATA;
		sctrl.first = (rcv_q == '0);
		sctrl.pos   = rcv_q[1:0];
		scanning    = 1'b1;
		unique case (state_q)
			ST_DHDR: begin
				scan_len = SCAN_W'(HDR_LEN);
				sctrl.op = OP_HDR;
			end
			ST_CHDR: begin
				scan_len     = SCAN_W'(HDR_LEN);
				sctrl.op     = OP_HDR;
				sctrl.fourth = HDR_CMD;
			end
			ST_DSUM: begin
				scan_len = SCAN_W'(DATA_LEN - 1);
				sctrl.op = OP_SUM;
			end
			ST_CSUM: begin
				scan_len = SCAN_W'(CMD_LEN - 1);
				sctrl.op = OP_SUM;
			end
			ST_WORD: begin
				scan_len = SCAN_W'(WORD_BYTES);
				sctrl.op = OP_WORD;
			end
			default: begin
				scanning = 1'b0;
			end
		endcase
	end

	assign rd_en       = scanning & (iss_q < scan_len);
	assign rd_addr     = base_q + AW'(iss_q);
	assign scan_done   = scanning & (rcv_q == scan_len);

	sfr_buffer #(
		.DEPTH (BUF_LEN),
		.AW    (AW)
	) u_buffer (
		.clk   (clk),
		.we    (wr_en),
		.waddr (cnt_q[AW-1:0]),
		.wdata (rx_byte),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	sfr_scan_unit u_scan (
		.clk       (clk),
		.din_valid (rd_vld_s1),
		.din       (rd_data),
		.ctrl      (sctrl),
		.hdr_ok    (hdr_ok),
		.sum       (sum),
		.word      (word)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			iss_q       <= '0;
			rcv_q       <= '0;
			rd_vld_s1   <= 1'b0;
			ch_q        <= '0;
			res_kind_q  <= K_STORED;
			pin_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (rd_en) begin
				iss_q <= iss_q + SCAN_W'(1);
			end
			if (rd_vld_s1) begin
				rcv_q <= rcv_q + SCAN_W'(1);
			end
			if (ld_put | ld_res) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						pin_q <= 1'b0;
						iss_q <= '0;
						rcv_q <= '0;
						if (!wr_en) begin
							cnt_q      <= '0;
							res_kind_q <= K_OVERFLOW;
							state_q    <= ST_RES;
						end else begin
							cnt_q <= cnt_inc;
							if (cnt_inc >= CW'(DATA_LEN)) begin
								state_q <= ST_DHDR;
							end else if (cnt_inc >= CW'(CMD_LEN)) begin
								state_q <= ST_CHDR;
							end else begin
								res_kind_q <= K_STORED;
								state_q    <= ST_RES;
							end
						end
					end
				end
				ST_DHDR: begin
					if (scan_done) begin
						iss_q <= '0;
						rcv_q <= '0;
						if (hdr_ok) begin
							cnt_q   <= '0;
							state_q <= ST_DSUM;
						end else begin
							state_q <= ST_CHDR;
						end
					end
				end
				ST_CHDR: begin
					if (scan_done) begin
						iss_q <= '0;
						rcv_q <= '0;
						if (hdr_ok) begin
							cnt_q   <= '0;
							state_q <= ST_CSUM;
						end else begin
							res_kind_q <= K_STORED;
							state_q    <= ST_RES;
						end
					end
				end
				ST_DSUM: begin
					if (scan_done) begin
						iss_q <= '0;
						rcv_q <= '0;
						if (sum == byte_q) begin
							ch_q    <= '0;
							state_q <= ST_WORD;
						end else begin
							res_kind_q <= K_DATA_BAD;
							state_q    <= ST_RES;
						end
					end
				end
				ST_CSUM: begin
					if (scan_done) begin
						if (sum == byte_q) begin
							// word holds number in [15:8], data in [7:0]
							if (word[7:0] == CMD_PIN_SET) begin
								pin_q <= 1'b1;
							end
							res_kind_q <= K_COMMAND;
						end else begin
							res_kind_q <= K_CMD_BAD;
						end
						state_q <= ST_RES;
					end
				end
				ST_WORD: begin
					if (scan_done) begin
						state_q <= ST_PUT;
					end
				end
				ST_PUT: begin
					if (out_free) begin
						iss_q <= '0;
						rcv_q <= '0;
						if (ch_q == CH_W'(NUM_CHANNELS - 1)) begin
							state_q <= ST_IDLE;
						end else begin
							ch_q    <= ch_q + CH_W'(1);
							state_q <= ST_WORD;
						end
					end
				end
				ST_RES: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload: window base, newest byte and the output word
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= rx_byte;
			if (cnt_inc >= CW'(DATA_LEN)) begin
				base_q <= AW'(cnt_inc - CW'(DATA_LEN));
			end else begin
				base_q <= AW'(cnt_inc - CW'(CMD_LEN));
			end
		end else if ((state_q == ST_DHDR) && scan_done && !hdr_ok) begin
			base_q <= base_q + AW'(DATA_LEN - CMD_LEN);
		end else if ((state_q == ST_DSUM) && scan_done) begin
			base_q <= base_q + AW'(HDR_LEN);
		end else if (ld_put) begin
			base_q <= base_q + AW'(WORD_BYTES);
		end

		if (ld_put) begin
			kind_q    <= K_CHANNEL;
			channel_q <= ch_q;
			value_q   <= map_channel(word);
			num_q     <= '0;
			dat_q     <= '0;
			pin_out_q <= pin_q;
			last_q    <= (ch_q == CH_W'(NUM_CHANNELS - 1));
		end else if (ld_res) begin
			kind_q    <= res_kind_q;
			channel_q <= '0;
			value_q   <= '0;
			num_q     <= (res_kind_q == K_COMMAND) ? word[15:8] : 8'd0;
			dat_q     <= (res_kind_q == K_COMMAND) ? word[7:0] : 8'd0;
			pin_out_q <= pin_q;
			last_q    <= 1'b1;
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = kind_q;
	assign channel       = channel_q;
	assign channel_value = value_q;
	assign cmd_number    = num_q;
	assign cmd_data      = dat_q;
	assign pin_level     = pin_out_q;
	assign last          = last_q;

endmodule

FILE: hw/rtl/sfr_buffer.sv
// Byte buffer of the serial frame receiver: one write and one registered read port.
// Depends on nothing beyond its parameters.
module sfr_buffer #(
	parameter int DEPTH = 100,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/sfr_scan_unit.sv
// Shared byte unit: header compare, mod-256 sum and 32-bit word shift.
// Depends on sfr_pkg.
module sfr_scan_unit
	import sfr_pkg::*;
(
	input  logic        clk,
	input  logic        din_valid,
	input  logic [7:0]  din,
	input  scan_ctrl_t  ctrl,
	output logic        hdr_ok,
	output logic [7:0]  sum,
	output logic [31:0] word
);

	logic        hdr_ok_q;
	logic [7:0]  sum_q;
	logic [31:0] word_q;
	logic        match;

	assign match = (din == hdr_byte(ctrl.pos, ctrl.fourth));

	always_ff @(posedge clk) begin
		if (din_valid) begin
			case (ctrl.op)
				OP_HDR: begin
					hdr_ok_q <= match & (ctrl.first | hdr_ok_q);
				end
				OP_SUM: begin
					sum_q  <= ctrl.first ? din : sum_q + din;
					word_q <= {word_q[23:0], din};
				end
				OP_WORD: begin
					word_q <= {word_q[23:0], din};
				end
				default: begin
				end
			endcase
		end
	end

	assign hdr_ok = hdr_ok_q;
	assign sum    = sum_q;
	assign word   = word_q;

endmodule
